/* rtl/tlec_pkg.sv */
// Shared types and constants of the two-level event channel controller.
// No dependencies; most other files of the block import this package.
package tlec_pkg;

    // Fixed field widths of the channels
    localparam int TLEC_CMD_W  = 3;
    localparam int TLEC_PORT_W = 6;

    // Default geometry
    localparam int TLEC_PORTS      = 64;
    localparam int TLEC_GROUP_BITS = 16;

    // Command codes; codes 6 and 7 are ignored
    typedef enum logic [TLEC_CMD_W-1:0] {
        CMD_RAISE  = 3'd0,
        CMD_MASK   = 3'd1,
        CMD_UNMASK = 3'd2,
        CMD_BIND   = 3'd3,
        CMD_UNBIND = 3'd4,
        CMD_SCAN   = 3'd5
    } t_cmd;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the captured command to the bitmaps
        logic emit;   // deliver the lowest candidate port
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic scan_req;    // executed command starts a scan
        logic cand_empty;  // no candidate left to deliver
        logic slot_free;   // output register can take an item
        logic pick_last;   // current pick is the final one of the scan
    } t_sts;

endpackage

/* rtl/tlec_cmd_if.sv */
// Command channel interface: valid/ready plus command and port.
// Depends on tlec_pkg.
interface tlec_cmd_if;
    import tlec_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TLEC_CMD_W-1:0]  command;
    logic [TLEC_PORT_W-1:0] port;

    modport source (output valid, output command, output port, input ready);
    modport sink   (input valid, input command, input port, output ready);
endinterface

/* rtl/tlec_dlv_if.sv */
// Delivery channel interface: valid/ready plus delivered port, bound flag, last.
// Depends on tlec_pkg.
interface tlec_dlv_if;
    import tlec_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TLEC_PORT_W-1:0] delivered_port;
    logic                   is_bound;
    logic                   last;

    modport source (output valid, output delivered_port, output is_bound, output last,
                    input ready);
    modport sink   (input valid, input delivered_port, input is_bound, input last,
                    output ready);
endinterface

/* rtl/tlec_cfg_if.sv */
// Configuration write channel: valid/ready plus the upcall_masked bit.
// No dependencies.
interface tlec_cfg_if;
    logic valid;
    logic ready;
    logic upcall_masked;

    modport source (output valid, output upcall_masked, input ready);
    modport sink   (input valid, input upcall_masked, output ready);
endinterface

/* rtl/two_level_event_channel_controller.sv */
// Top level of the two-level event channel controller.
// Depends on tlec_pkg, tlec_cmd_if, tlec_dlv_if, tlec_cfg_if, tlec_ctrl, tlec_dp.
//
//  channel   dir  fields                               accepted when
//  i_cmd     in   command[2:0], port[5:0]              valid & ready
//  o_dlv     out  delivered_port[5:0], is_bound, last  valid & ready
//  i_cfg     in   upcall_masked                        valid & ready (ready tied high)
//
// Non-scanning commands are captured, then applied to the bitmaps.
// A scan is captured and executed, then the priority encoder picks the lowest
// candidate port each cycle that the output register can take it; a scan
// that delivers nothing still passes through the scan state.
// Reset is synchronous, active low, and clears all bitmaps and the group word.
// A stalled output holds the scan; the next command is taken while the final
// delivery still waits in the output register.
module two_level_event_channel_controller #(
    parameter int PORTS      = tlec_pkg::TLEC_PORTS,
    parameter int GROUP_BITS = tlec_pkg::TLEC_GROUP_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlec_cmd_if.sink   i_cmd,
    tlec_dlv_if.source o_dlv,
    tlec_cfg_if.sink   i_cfg
);
    import tlec_pkg::*;

    t_ctl ctl;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    // Sequencer
    tlec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Bitmaps and delivery
    tlec_dp #(
        .PORTS      (PORTS),
        .GROUP_BITS (GROUP_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_command   (i_cmd.command),
        .i_port      (i_cmd.port),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.upcall_masked),
        .o_out_valid (o_dlv.valid),
        .i_out_ready (o_dlv.ready),
        .o_out_port  (o_dlv.delivered_port),
        .o_out_bound (o_dlv.is_bound),
        .o_out_last  (o_dlv.last)
    );

endmodule

/* rtl/tlec_ctrl.sv */
// Controller state machine: sequences accept, execute and scan delivery.
// Depends on tlec_pkg; drives the datapath tlec_dp through t_ctl.
module tlec_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tlec_pkg::t_sts i_sts,
    output tlec_pkg::t_ctl o_ctl
);
    import tlec_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.scan_req ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.cand_empty) begin
                    n_state = ST_IDLE;
                end else if (i_sts.slot_free && i_sts.pick_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
            end
            ST_SCAN: begin
                o_ctl.emit = !i_sts.cand_empty && i_sts.slot_free;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/tlec_dp.sv */
// Datapath: pending/mask/bound bitmaps, group-select word, scan candidates,
// lowest-port priority encoder and the output register. Depends on tlec_pkg.
module tlec_dp #(
    parameter int PORTS      = tlec_pkg::TLEC_PORTS,
    parameter int GROUP_BITS = tlec_pkg::TLEC_GROUP_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tlec_pkg::t_ctl                   i_ctl,
    output tlec_pkg::t_sts                   o_sts,
    input  logic [tlec_pkg::TLEC_CMD_W-1:0]  i_command,
    input  logic [tlec_pkg::TLEC_PORT_W-1:0] i_port,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tlec_pkg::TLEC_PORT_W-1:0] o_out_port,
    output logic                             o_out_bound,
    output logic                             o_out_last
);
    import tlec_pkg::*;

    localparam int GROUPS = (PORTS + GROUP_BITS - 1) / GROUP_BITS;

    // Captured item
    t_cmd                   r_cmd;
    logic [TLEC_PORT_W-1:0] r_port;

    // Architectural state
    logic [PORTS-1:0]  r_pending, n_pending;
    logic [PORTS-1:0]  r_mask,    n_mask;
    logic [PORTS-1:0]  r_bound,   n_bound;
    logic [GROUPS-1:0] r_gsel,    n_gsel;
    logic [PORTS-1:0]  r_cand,    n_cand;
    logic              r_upcall_masked;

    // Output register
    logic                   r_out_valid;
    logic [TLEC_PORT_W-1:0] r_out_port;
    logic                   r_out_bound;
    logic                   r_out_last;

    logic [PORTS-1:0]       bitv;
    logic                   port_ok;
    logic [GROUPS-1:0]      gbit;
    logic [PORTS-1:0]       low;
    logic [TLEC_PORT_W-1:0] pick_idx;
    logic                   scan_req;
    logic                   slot_free;

    // One-hot decode of the captured port; ports beyond PORTS decode to zero
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            bitv[i] = (r_port == TLEC_PORT_W'(i));
        end
    end
    assign port_ok = |bitv;

    // Group bit of the captured port
    for (genvar g = 0; g < GROUPS; g++) begin : g_grp
        localparam int LO = g * GROUP_BITS;
        localparam int HI = ((g + 1) * GROUP_BITS < PORTS) ? (g + 1) * GROUP_BITS - 1
                                                             : PORTS - 1;
        assign gbit[g] = |bitv[HI:LO];
    end

    // Lowest candidate and its index
    assign low = r_cand & (~r_cand + PORTS'(1));
    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < PORTS; i++) begin
            if (low[i]) pick_idx = pick_idx | TLEC_PORT_W'(i);
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    // Command execution and delivery updates
    always_comb begin
        logic [GROUPS-1:0] gsel_upd;
        logic [PORTS-1:0]  expand;
        logic              trig;

        n_pending = r_pending;
        n_mask    = r_mask;
        n_bound   = r_bound;
        n_gsel    = r_gsel;
        n_cand    = r_cand;
        gsel_upd  = r_gsel;
        expand    = '0;
        scan_req  = 1'b0;
        trig      = 1'b0;

        if (i_ctl.exec) begin
            case (r_cmd)
                CMD_RAISE: begin
                    if (port_ok) begin
                        n_pending = r_pending | bitv;
                        if (!(|(r_mask & bitv)) && !(|(r_gsel & gbit))) begin
                            gsel_upd = r_gsel | gbit;
                        end
                    end
                end
                CMD_MASK: begin
                    n_mask = r_mask | bitv;
                end
                CMD_UNMASK, CMD_BIND: begin
                    if (port_ok) begin
                        if (r_cmd == CMD_BIND) n_bound = r_bound | bitv;
                        n_mask = r_mask & ~bitv;
                        trig   = (|(r_pending & bitv)) && !(|(r_gsel & gbit));
                        if (trig) begin
                            gsel_upd = r_gsel | gbit;
                            scan_req = !r_upcall_masked;
                        end
                    end
                end
                CMD_UNBIND: begin
                    n_mask  = r_mask | bitv;
                    n_bound = r_bound & ~bitv;
                end
                CMD_SCAN: begin
                    scan_req = 1'b1;
                end
                default: ;
            endcase

            // Expand the taken groups to their ports
            for (int i = 0; i < PORTS; i++) begin
                expand[i] = gsel_upd[i / GROUP_BITS];
            end

            n_gsel = gsel_upd;
            if (scan_req) begin
                n_cand = expand & n_pending & ~n_mask;
                n_gsel = '0;
            end
        end

        // Deliver the lowest candidate
        if (i_ctl.emit) begin
            n_pending = r_pending & ~low;
            n_cand    = r_cand & ~low;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_port <= i_port;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending       <= '0;
            r_mask          <= '0;
            r_bound         <= '0;
            r_gsel          <= '0;
            r_cand          <= '0;
            r_upcall_masked <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_mask    <= n_mask;
            r_bound   <= n_bound;
            r_gsel    <= n_gsel;
            r_cand    <= n_cand;
            if (i_cfg_valid) r_upcall_masked <= i_cfg_data;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_port  <= pick_idx;
            r_out_bound <= |(low & r_bound);
            r_out_last  <= ~|(r_cand & ~low);
        end
    end

    assign o_sts.scan_req   = scan_req;
    assign o_sts.cand_empty = ~|r_cand;
    assign o_sts.slot_free  = slot_free;
    assign o_sts.pick_last  = ~|(r_cand & ~low);

    assign o_out_valid = r_out_valid;
    assign o_out_port  = r_out_port;
    assign o_out_bound = r_out_bound;
    assign o_out_last  = r_out_last;

endmodule

/* rtl/tlec_checker.sv */
// Port-level checks of the event channel controller, bound to the top level.
// Depends on two_level_event_channel_controller and its interfaces.
module tlec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [5:0] i_out_port,
    input logic       i_out_last
);

    // A stalled delivery holds its item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_port))
        else $error("delivery changed while stalled");

    // One command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    // No command is taken while a non-final scan delivery waits at the output
    a_no_accept_mid_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("ready during an unfinished scan");

    // A waiting delivery at accept time is the final one of its scan
    a_accept_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_last)
        else $error("accept while a non-final delivery waits");

endmodule

bind two_level_event_channel_controller tlec_checker u_tlec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_dlv.valid),
    .i_out_ready (o_dlv.ready),
    .i_out_port  (o_dlv.delivered_port),
    .i_out_last  (o_dlv.last)
);

/* sim/two_level_event_channel_controller_tb.sv */
// Testbench for two_level_event_channel_controller: directed and random commands
// under varied idling, with a scoreboard that predicts every delivered port.
// Depends on tlec_pkg and the tlec_cmd_if, tlec_dlv_if and tlec_cfg_if interfaces.
`timescale 1ns / 100ps

module two_level_event_channel_controller_tb;
    import tlec_pkg::*;

    localparam int PORTS        = TLEC_PORTS;
    localparam int GROUP_BITS   = TLEC_GROUP_BITS;
    localparam int NGROUPS      = (PORTS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int HOT_PORTS    = 8;

    // Command codes the block ignores
    localparam logic [TLEC_CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [TLEC_CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [TLEC_PORT_W-1:0] port;
        logic                   bound;
        logic                   last;
    } t_delivery;

    // Event channel state mirror plus the queue of deliveries still owed
    class tlec_scoreboard;
        logic [PORTS-1:0]   pend_bits;
        logic [PORTS-1:0]   mask_bits;
        logic [PORTS-1:0]   bound_bits;
        logic [NGROUPS-1:0] group_sel;
        logic               upcall_flag;
        logic               upcall_masked;
        t_delivery          due_q[$];
        int                 mismatches;

        function new();
            pend_bits     = '0;
            mask_bits     = '0;
            bound_bits    = '0;
            group_sel     = '0;
            upcall_flag   = 1'b0;
            upcall_masked = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_upcall_masked(logic v);
            upcall_masked = v;
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        // Take the group word and queue every pending, unmasked port of it
        function void scan_groups();
            t_delivery d;
            int        first;
            first       = due_q.size();
            upcall_flag = 1'b0;
            for (int p = 0; p < PORTS; p++) begin
                if (group_sel[p / GROUP_BITS] && pend_bits[p] && !mask_bits[p]) begin
                    pend_bits[p] = 1'b0;
                    d.port       = TLEC_PORT_W'(p);
                    d.bound      = bound_bits[p];
                    d.last       = 1'b0;
                    due_q.push_back(d);
                end
            end
            group_sel = '0;
            if (due_q.size() > first)
                due_q[due_q.size() - 1].last = 1'b1;
        endfunction

        function void unmask_port(logic [TLEC_PORT_W-1:0] port);
            mask_bits[port] = 1'b0;
            if (pend_bits[port] && !group_sel[port / GROUP_BITS]) begin
                group_sel[port / GROUP_BITS] = 1'b1;
                upcall_flag                  = 1'b1;
                if (!upcall_masked)
                    scan_groups();
            end
        endfunction

        // Apply one accepted command
        function void note_command(logic [TLEC_CMD_W-1:0] cmd, logic [TLEC_PORT_W-1:0] port);
            if (cmd != CMD_SCAN && int'(port) >= PORTS)
                return;
            case (cmd)
                CMD_RAISE: begin
                    pend_bits[port] = 1'b1;
                    if (!mask_bits[port] && !group_sel[port / GROUP_BITS]) begin
                        group_sel[port / GROUP_BITS] = 1'b1;
                        upcall_flag                  = 1'b1;
                    end
                end
                CMD_MASK:   mask_bits[port] = 1'b1;
                CMD_UNMASK: unmask_port(port);
                CMD_BIND: begin
                    bound_bits[port] = 1'b1;
                    unmask_port(port);
                end
                CMD_UNBIND: begin
                    mask_bits[port]  = 1'b1;
                    bound_bits[port] = 1'b0;
                end
                CMD_SCAN:   scan_groups();
                default:    ;
            endcase
        endfunction

        // Compare one delivered item with the oldest expectation
        function void check_delivery(t_delivery got);
            t_delivery want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected delivery port=%0d bound=%0b last=%0b",
                             $realtime, got.port, got.bound, got.last);
                return;
            end
            want = due_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %0d/%0b/%0b, got %0d/%0b/%0b (port/bound/last)",
                             $realtime, want.port, want.bound, want.last,
                             got.port, got.bound, got.last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   useful;
    logic [TLEC_PORT_W-1:0] hot[HOT_PORTS];

    tlec_cmd_if cmd_ch ();
    tlec_dlv_if dlv_ch ();
    tlec_cfg_if cfg_ch ();

    tlec_scoreboard sb = new();

    two_level_event_channel_controller u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_dlv   (dlv_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        dlv_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Delivery monitor
    always @(posedge i_clk) begin
        if (i_rst_n && dlv_ch.valid && dlv_ch.ready)
            sb.check_delivery('{dlv_ch.delivered_port, dlv_ch.is_bound, dlv_ch.last});
    end

    // Offer one command, with random sender gaps, and wait for acceptance
    task automatic send_command(logic [TLEC_CMD_W-1:0] cmd, logic [TLEC_PORT_W-1:0] port);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.port    <= port;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(cmd, port);
    endtask

    // Stop sending and let every owed delivery drain
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_upcall_masked(logic v);
        wait_idle();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.upcall_masked <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_upcall_masked(v);
    endtask

    // Mostly hot ports so the bitmaps interact; sometimes any port
    function automatic logic [TLEC_PORT_W-1:0] pick_port();
        if ($urandom_range(99) < 70)
            return hot[$urandom_range(HOT_PORTS - 1)];
        return TLEC_PORT_W'($urandom_range(PORTS - 1));
    endfunction

    task automatic random_phase(int items);
        int                     r;
        logic [TLEC_CMD_W-1:0]  cmd;
        for (int i = 0; i < HOT_PORTS; i++)
            hot[i] = TLEC_PORT_W'($urandom_range(PORTS - 1));
        useful = 0;
        while (useful < items) begin
            r = $urandom_range(99);
            if (r < 34)      cmd = CMD_RAISE;
            else if (r < 50) cmd = CMD_SCAN;
            else if (r < 62) cmd = CMD_MASK;
            else if (r < 75) cmd = CMD_UNMASK;
            else if (r < 86) cmd = CMD_BIND;
            else if (r < 94) cmd = CMD_UNBIND;
            else if (r < 97) cmd = CMD_RSVD6;
            else             cmd = CMD_RSVD7;
            if (cmd == CMD_SCAN)
                send_command(cmd, TLEC_PORT_W'($urandom_range(PORTS - 1)));
            else
                send_command(cmd, pick_port());
            if (cmd != CMD_RSVD6 && cmd != CMD_RSVD7)
                useful++;
        end
    endtask

    // Run limit
    initial begin
        #5ms;
        $display("two_level_event_channel_controller verification failed");
        $finish;
    end

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 51, 0, 27};
        stall_tab = '{0, 0, 51, 27};
        idle_pct  = 0;
        stall_pct = 0;

        i_rst_n              <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.command       <= CMD_RAISE;
        cmd_ch.port          <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.upcall_masked <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: immediate scans enabled
        write_upcall_masked(1'b0);
        send_command(CMD_RAISE, 6'd0);
        send_command(CMD_RAISE, 6'd63);
        send_command(CMD_SCAN, 6'd0);      // lowest and highest port, unbound
        send_command(CMD_BIND, 6'd5);      // bind with nothing pending
        send_command(CMD_MASK, 6'd5);
        send_command(CMD_RAISE, 6'd5);     // masked: no group bit
        send_command(CMD_SCAN, 6'd63);     // empty scan, port 5 stays pending
        send_command(CMD_UNMASK, 6'd5);    // scans at once, bound delivery
        send_command(CMD_UNBIND, 6'd5);
        send_command(CMD_RAISE, 6'd5);
        send_command(CMD_RAISE, 6'd6);
        send_command(CMD_SCAN, 6'd42);     // only port 6; 5 stays masked
        send_command(CMD_BIND, 6'd5);      // bind scans at once
        send_command(CMD_RSVD6, 6'd10);
        send_command(CMD_RSVD7, 6'd63);
        send_command(CMD_RAISE, 6'd42);
        send_command(CMD_RAISE, 6'd21);
        send_command(CMD_SCAN, 6'd21);
        send_command(CMD_UNBIND, 6'd33);   // unbind of a port never bound

        // Directed: immediate scans suppressed
        write_upcall_masked(1'b1);
        send_command(CMD_MASK, 6'd30);
        send_command(CMD_RAISE, 6'd30);
        send_command(CMD_UNMASK, 6'd30);   // group set, no scan yet
        send_command(CMD_BIND, 6'd31);
        send_command(CMD_SCAN, 6'd0);

        // Random phases, one idling profile each, register toggled between
        for (int ph = 0; ph < 4; ph++) begin
            write_upcall_masked(ph[0] == 1'b0);
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("two_level_event_channel_controller verification clean");
        else
            $display("two_level_event_channel_controller verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tlec_pkg.sv
rtl/tlec_cmd_if.sv
rtl/tlec_dlv_if.sv
rtl/tlec_cfg_if.sv
rtl/tlec_ctrl.sv
rtl/tlec_dp.sv
rtl/two_level_event_channel_controller.sv
rtl/tlec_checker.sv
sim/two_level_event_channel_controller_tb.sv
